@@ rtl/color_temperature_tint_hsl_top_defines.svh @@
// Assertion macros for the color tint block.
`ifndef COLOR_TEMPERATURE_TINT_HSL_TOP_DEFINES_SVH
`define COLOR_TEMPERATURE_TINT_HSL_TOP_DEFINES_SVH
`ifndef SYNTH
`define CTH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CTH_ASSERT_I(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CTH_ASSERT(lbl, prop, msg)
`define CTH_ASSERT_I(lbl, prop, msg)
`endif
`endif

@@ rtl/cth_pkg.sv @@
package cth_pkg;

  localparam int Q13W           = 14;
  localparam int DIV_W          = 14;
  localparam int DVS_W          = 7;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = DIV_W / BITS_PER_STAGE;
  localparam int CW             = 24;
  // input register, two front stages, divider, four back stages, output register
  localparam int LATENCY        = 8 + DIV_STAGES;

  localparam logic [1:0] REG_TINT_RED   = 2'd0;
  localparam logic [1:0] REG_TINT_GREEN = 2'd1;
  localparam logic [1:0] REG_TINT_BLUE  = 2'd2;

  localparam logic [7:0] TINT_RED_RST   = 8'd255;
  localparam logic [7:0] TINT_GREEN_RST = 8'd67;
  localparam logic [7:0] TINT_BLUE_RST  = 8'd0;

  localparam logic [Q13W-1:0] LUM_HALF = 14'd4096;
  localparam logic [Q13W-1:0] Q13_ONE  = 14'd8192;
  localparam logic [12:0]     BYTE_TOP = 13'd7710;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } result_t;

  // v*8192/255 = 32v + floor(32v/255)
  function automatic logic [Q13W-1:0] to_q13(logic [7:0] v);
    logic [12:0]     x;
    logic [Q13W-1:0] t;
    x = {v, 5'b0};
    t = {1'b0, x} + {9'b0, x[12:8]} + 14'd1;
    return {1'b0, x} + {8'b0, t[13:8]};
  endfunction

  function automatic logic [7:0] gray_byte(logic [Q13W-1:0] l);
    logic [21:0] m;
    m = {l, 8'b0} - {8'b0, l};
    return m[20:13];
  endfunction

  function automatic logic [7:0] to_byte(logic signed [CW-1:0] c);
    logic [20:0] m;
    m = {c[12:0], 8'b0} - {8'b0, c[12:0]};
    if (c < 0) begin
      return 8'd0;
    end else if (c > signed'(CW'(BYTE_TOP))) begin
      return 8'd255;
    end
    return m[20:13];
  endfunction

endpackage

@@ rtl/color_temperature_tint_hsl_top.sv @@
// Color temperature tint with lightness preserved.
// Pixel channel: drive pixel_i and pulse start_i; a beat is taken on every
//   clock edge where start_i is high and busy_o is low. busy_o stays low, so
//   a new pixel may enter on every cycle.
// Result channel: done_o is high for one cycle with result_o holding the
//   tinted pixel; the receiver must take it in that cycle.
// Throughput is one pixel per clock. A pixel passes the front conversion,
//   the two 7-stage dividers (saturation and hue, two quotient bits a
//   stage), which run side by side, and the two multiply stages behind
//   them on its way to done_o.
// Config port: cfg_we_i writes cfg_wdata_i into the tint register picked by
//   cfg_idx_i (0 red, 1 green, 2 blue); other indexes are dropped. Write only
//   while no pixel is in flight.
// Reset: rst_ni clears all valid bits at once and loads the tint color
//   (255, 67, 0); no result appears until a pixel has been taken.
`include "color_temperature_tint_hsl_top_defines.svh"

module color_temperature_tint_hsl_top import cth_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  pixel_t     pixel_i,
  output logic       done_o,
  output result_t    result_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  typedef enum logic [1:0] {
    HUE_R = 2'd0,
    HUE_G = 2'd1,
    HUE_B = 2'd2
  } hue_reg_e;

  // stage payloads
  typedef struct packed {
    logic            valid;
    logic [Q13W-1:0] pr, pg, pb, tr, tg, tb;
  } s1_t;

  typedef struct packed {
    logic            valid;
    logic [Q13W-1:0] lumi, br, bg, bb, mx, mn;
    logic            rmax, gmax;
  } s2_t;

  typedef struct packed {
    logic             valid;
    logic             ok;
    logic             neg;
    hue_reg_e         sec;
    logic [Q13W-1:0]  lumi;
    logic [DIV_W-1:0] d;
    logic [DVS_W-1:0] sdiv;
    logic [DIV_W-1:0] mag;
    logic [DVS_W-1:0] hdiv;
  } s3_t;

  typedef struct packed {
    logic            valid;
    logic            ok;
    logic            neg;
    hue_reg_e        sec;
    logic [Q13W-1:0] lumi;
  } side_t;

  typedef struct packed {
    logic               valid;
    logic               gray;
    logic               lo;
    logic [Q13W-1:0]    lumi;
    logic signed [16:0] h;
    logic signed [20:0] a;
    logic signed [21:0] b;
  } s4_t;

  typedef struct packed {
    logic               valid;
    logic               gray;
    logic               lo;
    logic [Q13W-1:0]    lumi;
    logic signed [16:0] h;
    logic signed [42:0] prod;
  } s5_t;

  typedef struct packed {
    logic                valid;
    logic                gray;
    logic [7:0]          gval;
    hue_reg_e            rgn;
    logic                sub;
    logic signed [CW-1:0] p, q, span;
    logic signed [16:0]  hh;
  } s6_t;

  typedef struct packed {
    logic                valid;
    logic                gray;
    logic [7:0]          gval;
    hue_reg_e            rgn;
    logic                sub;
    logic signed [CW-1:0] p, q;
    logic signed [40:0]  prod;
  } s7_t;

  logic [7:0] tint_r_q, tint_g_q, tint_b_q;
  s1_t   s1_q, s1_d;
  s2_t   s2_q, s2_d;
  s3_t   s3_q, s3_d;
  side_t side_q [DIV_STAGES];
  s4_t   s4_q, s4_d;
  s5_t   s5_q, s5_d;
  s6_t   s6_q, s6_d;
  s7_t   s7_q, s7_d;
  result_t result_q, result_d;
  logic    done_q;
  logic [DIV_W-1:0] sq, hq;

  assign busy_o   = 1'b0;
  assign done_o   = done_q;
  assign result_o = result_q;

  // tint registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tint_r_q <= TINT_RED_RST;
      tint_g_q <= TINT_GREEN_RST;
      tint_b_q <= TINT_BLUE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TINT_RED:   tint_r_q <= cfg_wdata_i;
        REG_TINT_GREEN: tint_g_q <= cfg_wdata_i;
        REG_TINT_BLUE:  tint_b_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage 1: Q13 conversion of pixel and tint
  always_comb begin
    s1_d.valid = start_i && !busy_o;
    s1_d.pr    = to_q13(pixel_i.pixel_red);
    s1_d.pg    = to_q13(pixel_i.pixel_green);
    s1_d.pb    = to_q13(pixel_i.pixel_blue);
    s1_d.tr    = to_q13(tint_r_q);
    s1_d.tg    = to_q13(tint_g_q);
    s1_d.tb    = to_q13(tint_b_q);
  end

  // stage 2: original lightness, blend, blend extremes
  always_comb begin : p_s2
    logic [Q13W-1:0] pmax, pmin;
    logic [Q13W:0]   psum;
    pmax = (s1_q.pr > s1_q.pg) ? s1_q.pr : s1_q.pg;
    pmax = (pmax > s1_q.pb) ? pmax : s1_q.pb;
    pmin = (s1_q.pr < s1_q.pg) ? s1_q.pr : s1_q.pg;
    pmin = (pmin < s1_q.pb) ? pmin : s1_q.pb;
    psum = {1'b0, pmax} + {1'b0, pmin};
    s2_d.valid = s1_q.valid;
    s2_d.lumi  = psum[Q13W:1];
    s2_d.br    = 14'(({1'b0, s1_q.tr} + {1'b0, s1_q.pr}) >> 1);
    s2_d.bg    = 14'(({1'b0, s1_q.tg} + {1'b0, s1_q.pg}) >> 1);
    s2_d.bb    = 14'(({1'b0, s1_q.tb} + {1'b0, s1_q.pb}) >> 1);
    s2_d.mx    = (s2_d.br > s2_d.bg) ? s2_d.br : s2_d.bg;
    s2_d.mx    = (s2_d.mx > s2_d.bb) ? s2_d.mx : s2_d.bb;
    s2_d.mn    = (s2_d.br < s2_d.bg) ? s2_d.br : s2_d.bg;
    s2_d.mn    = (s2_d.mn < s2_d.bb) ? s2_d.mn : s2_d.bb;
    s2_d.rmax  = s2_d.mx == s2_d.br;
    s2_d.gmax  = s2_d.mx == s2_d.bg;
  end

  // stage 3: divider operands
  always_comb begin : p_s3
    logic [Q13W:0]        sum, nsum;
    logic [Q13W-1:0]      lum;
    logic signed [Q13W:0] num;
    sum  = {1'b0, s2_q.mx} + {1'b0, s2_q.mn};
    nsum = 15'd16384 - sum;
    lum  = sum[Q13W:1];
    if (s2_q.rmax) begin
      num      = signed'({1'b0, s2_q.bg}) - signed'({1'b0, s2_q.bb});
      s3_d.sec = HUE_R;
    end else if (s2_q.gmax) begin
      num      = signed'({1'b0, s2_q.bb}) - signed'({1'b0, s2_q.br});
      s3_d.sec = HUE_G;
    end else begin
      num      = signed'({1'b0, s2_q.br}) - signed'({1'b0, s2_q.bg});
      s3_d.sec = HUE_B;
    end
    s3_d.valid = s2_q.valid;
    s3_d.lumi  = s2_q.lumi;
    s3_d.d     = s2_q.mx - s2_q.mn;
    s3_d.sdiv  = (lum <= LUM_HALF) ? sum[13:7] : nsum[13:7];
    s3_d.hdiv  = s3_d.d[13:7];
    s3_d.neg   = num[Q13W];
    s3_d.mag   = s3_d.neg ? 14'(-num) : num[Q13W-1:0];
    // gray blend or a zero divisor: no hue, no saturation
    s3_d.ok    = (s2_q.mx != s2_q.mn) && (s3_d.sdiv != '0) && (s3_d.hdiv != '0);
  end

  cth_div u_sat_div (
    .clk_i      (clk_i),
    .dividend_i (s3_q.d),
    .divisor_i  (s3_q.sdiv),
    .quotient_o (sq)
  );

  cth_div u_hue_div (
    .clk_i      (clk_i),
    .dividend_i (s3_q.mag),
    .divisor_i  (s3_q.hdiv),
    .quotient_o (hq)
  );

  // stage 4: saturation, hue, multiply operands
  always_comb begin : p_s4
    side_t              sd;
    logic [19:0]        s_val;
    logic signed [16:0] off, hmag;
    sd    = side_q[DIV_STAGES-1];
    s_val = {sq, 6'b0};
    // hue quotient stays below 256
    hmag  = signed'(17'({hq[7:0], 6'b0}));
    unique case (sd.sec)
      HUE_R:   off = 17'sd0;
      HUE_G:   off = 17'sd16384;
      HUE_B:   off = 17'sd32768;
      default: off = 17'sd0;
    endcase
    s4_d.valid = sd.valid;
    s4_d.gray  = !sd.ok || (sq == '0);
    s4_d.lo    = sd.lumi <= LUM_HALF;
    s4_d.lumi  = sd.lumi;
    s4_d.h     = sd.neg ? off - hmag : off + hmag;
    s4_d.a     = s4_d.lo ? signed'(21'(sd.lumi)) : signed'(21'(s_val));
    s4_d.b     = s4_d.lo ? signed'(22'(Q13_ONE)) - signed'(22'(s_val))
                         : signed'(22'(Q13_ONE)) - signed'(22'(sd.lumi));
  end

  // stage 5: lightness product
  always_comb begin
    s5_d.valid = s4_q.valid;
    s5_d.gray  = s4_q.gray;
    s5_d.lo    = s4_q.lo;
    s5_d.lumi  = s4_q.lumi;
    s5_d.h     = s4_q.h;
    s5_d.prod  = s4_q.a * s4_q.b;
  end

  // stage 6: p, q, span and hue sector
  always_comb begin : p_s6
    logic signed [29:0]   sh;
    logic signed [CW-1:0] l;
    sh = 30'(s5_q.prod >>> 13);
    l  = signed'(CW'(s5_q.lumi));
    s6_d.valid = s5_q.valid;
    s6_d.gray  = s5_q.gray;
    s6_d.gval  = gray_byte(s5_q.lumi);
    s6_d.q     = s5_q.lo ? CW'(sh) : l - CW'(sh);
    s6_d.p     = (l <<< 1) - s6_d.q;
    s6_d.span  = s6_d.p - s6_d.q;
    if (s5_q.h < 17'sd8192) begin
      s6_d.rgn = HUE_R;
      s6_d.hh  = s5_q.h;
    end else if (s5_q.h < 17'sd24576) begin
      s6_d.rgn = HUE_G;
      s6_d.hh  = s5_q.h - 17'sd16384;
    end else begin
      s6_d.rgn = HUE_B;
      s6_d.hh  = s5_q.h - 17'sd32768;
    end
    s6_d.sub = s6_d.hh < 17'sd0;
  end

  // stage 7: hue ramp product
  always_comb begin
    s7_d.valid = s6_q.valid;
    s7_d.gray  = s6_q.gray;
    s7_d.gval  = s6_q.gval;
    s7_d.rgn   = s6_q.rgn;
    s7_d.sub   = s6_q.sub;
    s7_d.p     = s6_q.p;
    s7_d.q     = s6_q.q;
    s7_d.prod  = s6_q.hh * s6_q.span;
  end

  // stage 8: channel placement and byte mapping
  always_comb begin : p_s8
    logic signed [CW-1:0] t, mid, cr, cg, cb;
    t   = CW'(s7_q.prod >>> 13);
    mid = s7_q.sub ? s7_q.q - t : s7_q.q + t;
    unique case (s7_q.rgn)
      HUE_R: begin
        cr = s7_q.p;
        cg = s7_q.sub ? s7_q.q : mid;
        cb = s7_q.sub ? mid : s7_q.q;
      end
      HUE_G: begin
        cg = s7_q.p;
        cb = s7_q.sub ? s7_q.q : mid;
        cr = s7_q.sub ? mid : s7_q.q;
      end
      HUE_B: begin
        cb = s7_q.p;
        cr = s7_q.sub ? s7_q.q : mid;
        cg = s7_q.sub ? mid : s7_q.q;
      end
      default: begin
        cr = s7_q.p;
        cg = s7_q.p;
        cb = s7_q.p;
      end
    endcase
    if (s7_q.gray) begin
      result_d.out_red   = s7_q.gval;
      result_d.out_green = s7_q.gval;
      result_d.out_blue  = s7_q.gval;
    end else begin
      result_d.out_red   = to_byte(cr);
      result_d.out_green = to_byte(cg);
      result_d.out_blue  = to_byte(cb);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      s2_q   <= '0;
      s3_q   <= '0;
      side_q <= '{default: '0};
      s4_q   <= '0;
      s5_q   <= '0;
      s6_q   <= '0;
      s7_q   <= '0;
      done_q <= 1'b0;
    end else begin
      s1_q      <= s1_d;
      s2_q      <= s2_d;
      s3_q      <= s3_d;
      side_q[0] <= '{valid: s3_q.valid, ok: s3_q.ok, neg: s3_q.neg,
                     sec: s3_q.sec, lumi: s3_q.lumi};
      for (int i = 1; i < DIV_STAGES; i++) begin
        side_q[i] <= side_q[i-1];
      end
      s4_q   <= s4_d;
      s5_q   <= s5_d;
      s6_q   <= s6_d;
      s7_q   <= s7_d;
      done_q <= s7_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  // all three output channels agree
  logic rgb_same;
  assign rgb_same = (result_q.out_red == result_q.out_green) &&
                    (result_q.out_green == result_q.out_blue);

  `CTH_ASSERT(a_latency, start_i |-> ##LATENCY done_o, "pixel beat did not come out on time")
  `CTH_ASSERT(a_gray_out, s7_q.valid && s7_q.gray |=> rgb_same, "gray blend gave unequal channels")
  `CTH_ASSERT_I(a_rst_quiet, !rst_ni |=> !done_o, "result strobe during reset")

endmodule

@@ rtl/cth_div.sv @@
module cth_div import cth_pkg::*; (
  input  logic             clk_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic [DIV_W-1:0] quotient_o
);

  // restoring division, quotient bits shift into the dividend word
  logic [DVS_W-1:0] rem_in  [DIV_STAGES];
  logic [DIV_W-1:0] work_in [DIV_STAGES];
  logic [DVS_W-1:0] dvs_in  [DIV_STAGES];
  logic [DVS_W-1:0] rem_d   [DIV_STAGES];
  logic [DIV_W-1:0] work_d  [DIV_STAGES];
  logic [DVS_W-1:0] rem_q   [DIV_STAGES];
  logic [DIV_W-1:0] work_q  [DIV_STAGES];
  logic [DVS_W-1:0] dvs_q   [DIV_STAGES];

  assign rem_in[0]  = '0;
  assign work_in[0] = dividend_i;
  assign dvs_in[0]  = divisor_i;

  for (genvar g = 1; g < DIV_STAGES; g++) begin : g_link
    assign rem_in[g]  = rem_q[g-1];
    assign work_in[g] = work_q[g-1];
    assign dvs_in[g]  = dvs_q[g-1];
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    always_comb begin : p_step
      logic [DVS_W-1:0] r;
      logic [DIV_W-1:0] w;
      logic [DVS_W:0]   t;
      r = rem_in[g];
      w = work_in[g];
      for (int i = 0; i < BITS_PER_STAGE; i++) begin
        t = {r, w[DIV_W-1]};
        if (t >= {1'b0, dvs_in[g]}) begin
          t = t - {1'b0, dvs_in[g]};
          w = {w[DIV_W-2:0], 1'b1};
        end else begin
          w = {w[DIV_W-2:0], 1'b0};
        end
        r = t[DVS_W-1:0];
      end
      rem_d[g]  = r;
      work_d[g] = w;
    end

    always_ff @(posedge clk_i) begin
      rem_q[g]  <= rem_d[g];
      work_q[g] <= work_d[g];
      dvs_q[g]  <= dvs_in[g];
    end
  end

  assign quotient_o = work_q[DIV_STAGES-1];

endmodule
